// ===== src/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants, codes and types of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   // sizes
   localparam int CAPACITY    = 128;
   localparam int KEY_W       = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 8;

   // operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_REM_LOAD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_TOP_RD,
      ST_TOP_WAIT
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic ins_start;
      logic rem_start;
      logic fail_full;
      logic fail_empty;
      logic rd_parent;
      logic up_step;
      logic rem_load;
      logic rd_kids;
      logic dn_step;
      logic place;
      logic rd_top;
      logic publish;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic at_root;
      logic leaf;
      logic up_move;
      logic dn_move;
   } dp_stat_type;

endpackage

// ===== src/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic memory: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]                      rd_data_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                      rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== src/mhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer for insert (sift up) and remove (sift down) items.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_func,
   input  mhpq_pkg::dp_stat_type stat,
   output mhpq_pkg::dp_cmd_type  cmd,
   output logic                  busy
);

   mhpq_pkg::ctrl_state_type state_ff;
   mhpq_pkg::ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhpq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         mhpq_pkg::ST_IDLE: begin
            if (start) begin
               if (req_func == mhpq_pkg::FUNC_INSERT) begin
                  if (stat.full) begin
                     cmd.fail_full = 1'b1;
                     state_in      = mhpq_pkg::ST_TOP_RD;
                  end else begin
                     cmd.ins_start = 1'b1;
                     state_in      = mhpq_pkg::ST_UP_RD;
                  end
               end else begin
                  if (stat.empty) begin
                     cmd.fail_empty = 1'b1;
                     state_in       = mhpq_pkg::ST_TOP_RD;
                  end else begin
                     cmd.rem_start = 1'b1;
                     state_in      = mhpq_pkg::ST_REM_LOAD;
                  end
               end
            end
         end
         mhpq_pkg::ST_UP_RD: begin
            if (stat.at_root) begin
               cmd.place = 1'b1;
               state_in  = mhpq_pkg::ST_TOP_RD;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = mhpq_pkg::ST_UP_CMP;
            end
         end
         mhpq_pkg::ST_UP_CMP: begin
            if (stat.up_move) begin
               cmd.up_step = 1'b1;
               state_in    = mhpq_pkg::ST_UP_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = mhpq_pkg::ST_TOP_RD;
            end
         end
         mhpq_pkg::ST_REM_LOAD: begin
            cmd.rem_load = 1'b1;
            state_in     = mhpq_pkg::ST_DN_RD;
         end
         mhpq_pkg::ST_DN_RD: begin
            if (stat.leaf) begin
               cmd.place = 1'b1;
               state_in  = mhpq_pkg::ST_TOP_RD;
            end else begin
               cmd.rd_kids = 1'b1;
               state_in    = mhpq_pkg::ST_DN_CMP;
            end
         end
         mhpq_pkg::ST_DN_CMP: begin
            if (stat.dn_move) begin
               cmd.dn_step = 1'b1;
               state_in    = mhpq_pkg::ST_DN_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = mhpq_pkg::ST_TOP_RD;
            end
         end
         mhpq_pkg::ST_TOP_RD: begin
            cmd.rd_top = 1'b1;
            state_in   = mhpq_pkg::ST_TOP_WAIT;
         end
         mhpq_pkg::ST_TOP_WAIT: begin
            cmd.publish = 1'b1;
            state_in    = mhpq_pkg::ST_IDLE;
         end
         default: begin
            state_in = mhpq_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != mhpq_pkg::ST_IDLE);

endmodule

// ===== src/mhpq_dp.sv =====
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap datapath: heap memory, count, hole position, moving key, result regs.
// ----------------------------------------------------------------------------
module mhpq_dp #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mhpq_pkg::dp_cmd_type                cmd,
   output mhpq_pkg::dp_stat_type               stat,
   input  logic signed [mhpq_pkg::KEY_W-1:0]   req_key,
   output logic                                rsp_strobe,
   output logic [mhpq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [mhpq_pkg::KEY_W-1:0]   rsp_removed_key,
   output logic [mhpq_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic signed [mhpq_pkg::KEY_W-1:0]   rsp_top_key
);

   localparam int KW    = mhpq_pkg::KEY_W;
   localparam int OUT_W = mhpq_pkg::COUNT_OUT_W;
   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int PW    = CW + 1;

   // control state
   logic [CW-1:0] count_ff, count_in;
   logic          strobe_ff, strobe_in;

   // payload state
   logic [PW-1:0]                  pos_ff, pos_in;
   logic signed [KW-1:0]           cur_ff, cur_in;
   logic signed [KW-1:0]           removed_ff, removed_in;
   logic [mhpq_pkg::STATUS_W-1:0]  code_ff, code_in;
   logic [mhpq_pkg::STATUS_W-1:0]  out_status_ff, out_status_in;
   logic signed [KW-1:0]           out_removed_ff, out_removed_in;
   logic [OUT_W-1:0]               out_count_ff, out_count_in;
   logic signed [KW-1:0]           out_top_ff, out_top_in;

   // memory ports
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [KW-1:0]        wr_data;
   logic [AW-1:0]        rd_addr_a;
   logic [AW-1:0]        rd_addr_b;
   logic signed [KW-1:0] rd_a;
   logic signed [KW-1:0] rd_b;

   // heap positions around the hole
   logic [PW-1:0]        par_pos;
   logic [PW-1:0]        left_pos;
   logic [PW-1:0]        right_pos;
   logic [AW-1:0]        pos_idx;
   logic                 take_right;
   logic [PW-1:0]        big_pos;
   logic signed [KW-1:0] big_val;

   mhpq_ram #(
      .WIDTH (KW),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_b)
   );

   assign par_pos   = pos_ff >> 1;
   assign left_pos  = pos_ff << 1;
   assign right_pos = left_pos | PW'(1);
   assign pos_idx   = AW'(pos_ff - PW'(1));

   // larger child, left unless right is in range and strictly greater
   assign take_right = (right_pos <= PW'(count_ff)) && (rd_b > rd_a);
   assign big_pos    = take_right ? right_pos : left_pos;
   assign big_val    = take_right ? rd_b : rd_a;

   // status to controller
   assign stat.full    = (count_ff == CW'(CAPACITY));
   assign stat.empty   = (count_ff == '0);
   assign stat.at_root = (pos_ff == PW'(1));
   assign stat.leaf    = (left_pos > PW'(count_ff));
   assign stat.up_move = (cur_ff > rd_a);
   assign stat.dn_move = (big_val > cur_ff);

   // next values and memory access
   always_comb begin
      count_in       = count_ff;
      pos_in         = pos_ff;
      cur_in         = cur_ff;
      removed_in     = removed_ff;
      code_in        = code_ff;
      strobe_in      = 1'b0;
      out_status_in  = out_status_ff;
      out_removed_in = out_removed_ff;
      out_count_in   = out_count_ff;
      out_top_in     = out_top_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_idx;
      wr_data        = cur_ff;
      rd_addr_a      = '0;
      rd_addr_b      = '0;

      // new item
      if (cmd.ins_start) begin
         count_in   = count_ff + CW'(1);
         pos_in     = PW'(count_ff) + PW'(1);
         cur_in     = req_key;
         code_in    = mhpq_pkg::STATUS_OK;
         removed_in = '0;
      end
      if (cmd.fail_full) begin
         code_in    = mhpq_pkg::STATUS_FULL;
         removed_in = '0;
      end
      if (cmd.fail_empty) begin
         code_in    = mhpq_pkg::STATUS_EMPTY;
         removed_in = '0;
      end
      if (cmd.rem_start) begin
         code_in    = mhpq_pkg::STATUS_OK;
         removed_in = '0;
         rd_addr_a  = '0;
         rd_addr_b  = AW'(count_ff - CW'(1));
      end

      // sift up: parent moves down into the hole
      if (cmd.rd_parent) begin
         rd_addr_a = AW'(par_pos - PW'(1));
      end
      if (cmd.up_step) begin
         wr_en   = 1'b1;
         wr_data = rd_a;
         pos_in  = par_pos;
      end

      // remove: take root, last entry becomes the moving key
      if (cmd.rem_load) begin
         removed_in = rd_a;
         cur_in     = rd_b;
         count_in   = count_ff - CW'(1);
         pos_in     = PW'(1);
      end

      // sift down: larger child moves up into the hole
      if (cmd.rd_kids) begin
         rd_addr_a = AW'(left_pos - PW'(1));
         rd_addr_b = AW'(right_pos - PW'(1));
      end
      if (cmd.dn_step) begin
         wr_en   = 1'b1;
         wr_data = big_val;
         pos_in  = big_pos;
      end

      // moving key settles in the hole
      if (cmd.place) begin
         wr_en = 1'b1;
      end

      // root readback and result
      if (cmd.rd_top) begin
         rd_addr_a = '0;
      end
      if (cmd.publish) begin
         strobe_in      = 1'b1;
         out_status_in  = code_ff;
         out_removed_in = removed_ff;
         out_count_in   = OUT_W'(count_ff);
         out_top_in     = (count_ff != '0) ? rd_a : '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      removed_ff     <= removed_in;
      code_ff        <= code_in;
      out_status_ff  <= out_status_in;
      out_removed_ff <= out_removed_in;
      out_count_ff   <= out_count_in;
      out_top_ff     <= out_top_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_removed_key = out_removed_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_top_key     = out_top_ff;

endmodule

// ===== src/max_heap_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top
// Binary max-heap priority queue: insert key / remove maximum, one result each.
// One item at a time; the next item is taken at the edge that takes the result.
// Each sift level takes a read state and a compare state on the single heap memory.
// Reset idles the sequencer and clears the count and strobe; heap memory is not
// cleared and needs no sweep. The receiver cannot stall the one-cycle strobe.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic signed [mhpq_pkg::KEY_W-1:0]   req_key,
   output logic                                rsp_strobe,
   output logic [mhpq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [mhpq_pkg::KEY_W-1:0]   rsp_removed_key,
   output logic [mhpq_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic signed [mhpq_pkg::KEY_W-1:0]   rsp_top_key
);

   mhpq_pkg::dp_cmd_type  cmd;
   mhpq_pkg::dp_stat_type stat;

   mhpq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   mhpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_key         (req_key),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_removed_key (rsp_removed_key),
      .rsp_entry_count (rsp_entry_count),
      .rsp_top_key     (rsp_top_key)
   );

   // an accepted item always keeps the block busy in the next cycle
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   // a result only appears once the sequencer is back at rest
   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while still working");

   // an empty remove reports an empty heap and no removed key
   a_empty_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == mhpq_pkg::STATUS_EMPTY)) |->
         ((rsp_entry_count == '0) && (rsp_removed_key == '0) && (rsp_top_key == '0)))
      else $error("empty remove result not cleared");

   // a full insert reports the capacity as the count
   a_full_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == mhpq_pkg::STATUS_FULL)) |->
         ((rsp_entry_count == mhpq_pkg::COUNT_OUT_W'(CAPACITY)) && (rsp_removed_key == '0)))
      else $error("full insert result inconsistent");

endmodule

// ===== tb/sv/max_heap_priority_queue_top_tb.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top_tb
// Self-checking bench for the max-heap priority queue. A driver issues insert
// and remove items from a pending queue, a local heap model predicts each
// result, and a monitor checks every strobed result field by field against
// the oldest prediction. Stimulus runs the heap to full and back to empty
// several times with random keys and random gaps between items.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top_tb;

   localparam int KEY_W       = mhpq_pkg::KEY_W;
   localparam int STATUS_W    = mhpq_pkg::STATUS_W;
   localparam int COUNT_OUT_W = mhpq_pkg::COUNT_OUT_W;
   localparam int CAPACITY    = mhpq_pkg::CAPACITY;

   localparam int ITEM_TARGET = 1650;
   localparam int SETTLE_CYCLES = 30;

   typedef struct {
      logic                    func;
      logic signed [KEY_W-1:0] key;
   } heap_op_type;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [KEY_W-1:0]  removed_key;
      logic [COUNT_OUT_W-1:0]   entry_count;
      logic signed [KEY_W-1:0]  top_key;
   } heap_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_func = mhpq_pkg::FUNC_INSERT;
   logic signed [KEY_W-1:0]     req_key = '0;
   logic                        rsp_strobe;
   logic [STATUS_W-1:0]         rsp_status;
   logic signed [KEY_W-1:0]     rsp_removed_key;
   logic [COUNT_OUT_W-1:0]      rsp_entry_count;
   logic signed [KEY_W-1:0]     rsp_top_key;

   heap_op_type      pending_ops[$];
   heap_result_type  expected_results[$];

   // local copy of the heap, positions counted from one
   logic signed [KEY_W-1:0] heap_keys [1:CAPACITY];
   int unsigned             heap_fill = 0;

   int mismatch_count = 0;
   int issued_count = 0;
   int insert_count = 0;
   int remove_count = 0;
   int full_count = 0;
   int empty_count = 0;
   int gen_fill = 0;

   max_heap_priority_queue_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_key         (req_key),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_removed_key (rsp_removed_key),
      .rsp_entry_count (rsp_entry_count),
      .rsp_top_key     (rsp_top_key)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mismatch reporting
   task automatic report_mismatch(input string field, input logic [KEY_W-1:0] want,
                                  input logic [KEY_W-1:0] got);
      $display("mismatch on %s: expected %0h, got %0h (t=%0t)", field, want, got, $time);
      mismatch_count++;
   endtask

   // heap model: apply one accepted item and queue its expected result
   function automatic void apply_heap_op(input logic func, input logic signed [KEY_W-1:0] key);
      heap_result_type         res;
      int unsigned             pos;
      int unsigned             kid;
      logic signed [KEY_W-1:0] tmp;
      res.status = mhpq_pkg::STATUS_OK;
      res.removed_key = '0;
      if (func == mhpq_pkg::FUNC_INSERT) begin
         insert_count++;
         if (heap_fill >= CAPACITY) begin
            res.status = mhpq_pkg::STATUS_FULL;
            full_count++;
         end else begin
            heap_fill++;
            heap_keys[heap_fill] = key;
            pos = heap_fill;
            // sift up while strictly greater than the parent
            while (pos > 1 && heap_keys[pos] > heap_keys[pos / 2]) begin
               tmp = heap_keys[pos];
               heap_keys[pos] = heap_keys[pos / 2];
               heap_keys[pos / 2] = tmp;
               pos = pos / 2;
            end
         end
      end else begin
         remove_count++;
         if (heap_fill == 0) begin
            res.status = mhpq_pkg::STATUS_EMPTY;
            empty_count++;
         end else begin
            res.removed_key = heap_keys[1];
            heap_keys[1] = heap_keys[heap_fill];
            heap_fill--;
            pos = 1;
            // sift down toward the larger child held within the count
            while (2 * pos <= heap_fill) begin
               kid = 2 * pos;
               if (kid + 1 <= heap_fill && heap_keys[kid + 1] > heap_keys[kid])
                  kid = kid + 1;
               if (heap_keys[kid] > heap_keys[pos]) begin
                  tmp = heap_keys[pos];
                  heap_keys[pos] = heap_keys[kid];
                  heap_keys[kid] = tmp;
                  pos = kid;
               end else begin
                  break;
               end
            end
         end
      end
      res.entry_count = heap_fill[COUNT_OUT_W-1:0];
      res.top_key = (heap_fill != 0) ? heap_keys[1] : '0;
      expected_results.push_back(res);
   endfunction

   // item source: queue one item and track the count it leaves behind
   function automatic void queue_op(input logic func, input logic signed [KEY_W-1:0] key);
      heap_op_type op;
      op.func = func;
      op.key = key;
      pending_ops.push_back(op);
      if (func == mhpq_pkg::FUNC_INSERT && gen_fill < CAPACITY)
         gen_fill++;
      else if (func == mhpq_pkg::FUNC_REMOVE && gen_fill > 0)
         gen_fill--;
   endfunction

   // keys: extremes, a narrow band for duplicates, or anything
   function automatic logic signed [KEY_W-1:0] pick_key();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: pick_key = 32'sh7fff_ffff;
         1: pick_key = 32'sh8000_0000;
         2, 3, 4: pick_key = $signed($urandom_range(0, 16)) - 8;
         default: pick_key = $urandom;
      endcase
   endfunction

   // random run with a given insert share
   function automatic void queue_mix(input int count, input int insert_pct);
      for (int i = 0; i < count && pending_ops.size() < ITEM_TARGET; i++) begin
         if ($urandom_range(0, 99) < insert_pct)
            queue_op(mhpq_pkg::FUNC_INSERT, pick_key());
         else
            queue_op(mhpq_pkg::FUNC_REMOVE, pick_key());
      end
   endfunction

   // driver: present items from the pending queue, hold while busy
   always @(posedge clock) begin : driver
      heap_op_type next_op;
      logic        quiet;
      quiet = (issued_count >= 600 && issued_count < 900);
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            apply_heap_op(req_func, req_key);
         if (start && busy) begin
            // item not yet taken, keep it on the ports
         end else if (pending_ops.size() != 0 && (quiet || $urandom_range(0, 99) >= 11)) begin
            next_op = pending_ops.pop_front();
            start <= 1'b1;
            req_func <= next_op.func;
            req_key <= next_op.key;
            issued_count++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check each strobed result against the oldest prediction
   always @(posedge clock) begin : monitor
      heap_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result top_key", '0, rsp_top_key);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", KEY_W'(want.status), KEY_W'(rsp_status));
            if (rsp_removed_key !== want.removed_key)
               report_mismatch("removed_key", want.removed_key, rsp_removed_key);
            if (rsp_entry_count !== want.entry_count)
               report_mismatch("entry_count", KEY_W'(want.entry_count),
                               KEY_W'(rsp_entry_count));
            if (rsp_top_key !== want.top_key)
               report_mismatch("top_key", want.top_key, rsp_top_key);
         end
      end
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("== FAIL ==");
      $finish;
   end

   // stimulus and end of run
   initial begin
      int round;
      // directed: empty remove, key extremes, duplicates, drain past empty
      queue_op(mhpq_pkg::FUNC_REMOVE, 32'sh1234_5678);
      queue_op(mhpq_pkg::FUNC_INSERT, 32'sh7fff_ffff);
      queue_op(mhpq_pkg::FUNC_INSERT, 32'sh8000_0000);
      queue_op(mhpq_pkg::FUNC_INSERT, 32'sh0000_0000);
      queue_op(mhpq_pkg::FUNC_INSERT, -32'sd1);
      queue_op(mhpq_pkg::FUNC_INSERT, 32'sh7fff_ffff);
      queue_op(mhpq_pkg::FUNC_INSERT, 32'sd1);
      for (int i = 0; i < 7; i++)
         queue_op(mhpq_pkg::FUNC_REMOVE, 32'shffff_ffff);
      queue_op(mhpq_pkg::FUNC_INSERT, 32'sd5);
      queue_op(mhpq_pkg::FUNC_INSERT, 32'sd5);
      queue_op(mhpq_pkg::FUNC_INSERT, 32'sd5);
      queue_op(mhpq_pkg::FUNC_INSERT, 32'sd7);
      for (int i = 0; i < 5; i++)
         queue_op(mhpq_pkg::FUNC_REMOVE, 32'sd0);

      // random: mixed runs, fill to full and beyond, drain to empty and beyond
      round = 0;
      while (pending_ops.size() < ITEM_TARGET) begin
         case (round % 4)
            1: begin
               while (gen_fill < CAPACITY && pending_ops.size() < ITEM_TARGET)
                  queue_mix(1, 90);
               for (int i = 0; i < 3; i++)
                  queue_op(mhpq_pkg::FUNC_INSERT, pick_key());
            end
            3: begin
               while (gen_fill > 0 && pending_ops.size() < ITEM_TARGET)
                  queue_mix(1, 10);
               for (int i = 0; i < 2; i++)
                  queue_op(mhpq_pkg::FUNC_REMOVE, pick_key());
            end
            default: queue_mix(60, 50);
         endcase
         round++;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || start || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d inserts (%0d on a full heap)", insert_count, full_count);
      $display("and %0d removes (%0d on an empty heap)", remove_count, empty_count);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
